/* rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg: shared types and codes for the positional array list
// Word formats of both channels, operation and status codes, and the
// control word that the list controller broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int LIST_DEPTH_DEFAULT = 128;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic signed [7:0] IDX_NONE = -8'sd1;

  // cell modes
  localparam logic [2:0] CM_HOLD   = 3'd0;
  localparam logic [2:0] CM_INSERT = 3'd1;
  localparam logic [2:0] CM_DELETE = 3'd2;
  localparam logic [2:0] CM_MATCH  = 3'd3;
  localparam logic [2:0] CM_SHIFT  = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [7:0] found_index;
    logic [7:0]        count;
    logic              is_empty;
    logic              is_full;
  } rsp_word_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  pos;
    logic [31:0] value;
  } cell_ctrl_t;

endpackage

/* rtl/pal_cell.sv */
// ----------------------------------------------------------------------------
// pal_cell: one entry of the positional array list
// Holds one stored word and one match flag. Takes its left neighbour's word
// on insert, its right neighbour's word on delete, and shifts match flags
// leftwards during a search scan.
// ----------------------------------------------------------------------------
module pal_cell #(
  parameter int IDX = 0,
  parameter int CW  = 8
) (
  input  logic                clk,
  input  pal_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic [31:0]         prev_entry,
  input  logic [31:0]         next_entry,
  input  logic                next_hit,
  output logic [31:0]         entry,
  output logic                hit
);
  import pal_pkg::*;

  localparam int XW = (CW > 8) ? CW : 8;

  logic [XW-1:0] idx_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;

  assign idx_x = XW'(IDX);
  assign pos_x = XW'(ctrl.pos);
  assign cnt_x = XW'(count);

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CM_INSERT: begin
        if (idx_x > pos_x) begin
          entry <= prev_entry;
        end else if (idx_x == pos_x) begin
          entry <= ctrl.value;
        end
      end
      CM_DELETE: begin
        if (idx_x >= pos_x) begin
          entry <= next_entry;
        end
      end
      CM_MATCH: begin
        hit <= (entry == ctrl.value) && (idx_x < cnt_x);
      end
      CM_SHIFT: begin
        hit <= next_hit;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/positional_array_list.sv */
// ----------------------------------------------------------------------------
// positional_array_list: ordered list of signed 32-bit words in a cell chain
// Insert, delete and search on a list held one entry per cell.
// ----------------------------------------------------------------------------
// Insert and delete: the result word is registered at the accepting edge, and a
// new word may be accepted in the next cycle if the output register is free or being drained.
// Search on an empty list answers not found without a scan. Else the match flags
// are latched and the scan covers match index + 1 entries, or the count on a miss;
// the match flags shift one cell per cycle towards cell 0, and no request is taken meanwhile.
// Reset (rst, synchronous) empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int LIST_DEPTH = pal_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  pal_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output pal_pkg::rsp_word_t rsp
);
  import pal_pkg::*;

  // count must hold LIST_DEPTH itself; index only needs to reach the last cell
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int XW = (CW > 8) ? CW : 8;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic          state;
  logic          state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] scan;
  logic [IW-1:0] scan_next;
  logic          rsp_valid_next;
  rsp_word_t     rsp_next;
  cell_ctrl_t    ctrl;

  logic [31:0]   entry_q [LIST_DEPTH];
  logic          hit_q   [LIST_DEPTH];

  logic          req_fire;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] cnt_next_x;
  logic [XW-1:0] scan_x;

  // Accept only when idle and the output register is free or being drained.
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;

  assign pos_x      = XW'(req.position);
  assign cnt_x      = XW'(count);
  assign cnt_next_x = XW'(count_next);
  assign scan_x     = XW'(scan);

  // --------------------------------------------------------------------------
  // Control: decide the operation, drive the cells, build the result word
  // --------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_next      = scan;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    ctrl.mode      = CM_HOLD;
    ctrl.pos       = req.position;
    ctrl.value     = $unsigned(req.value);

    rsp_next.status      = rsp.status;
    rsp_next.found_index = rsp.found_index;

    if (state == S_IDLE) begin
      if (req_fire) begin
        rsp_valid_next       = 1'b1;
        rsp_next.status      = ST_OK;
        rsp_next.found_index = IDX_NONE;
        case (req.operation)
          OP_INSERT: begin
            if (count == CW'(LIST_DEPTH)) begin
              rsp_next.status = ST_FULL;
            end else if (pos_x > cnt_x) begin
              rsp_next.status = ST_BADPOS;
            end else begin
              ctrl.mode  = CM_INSERT;
              count_next = count + CW'(1);
            end
          end
          OP_DELETE: begin
            if (count == '0) begin
              rsp_next.status = ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              rsp_next.status = ST_BADPOS;
            end else begin
              ctrl.mode  = CM_DELETE;
              count_next = count - CW'(1);
            end
          end
          OP_SEARCH: begin
            if (count == '0) begin
              rsp_next.status = ST_NOTFOUND;
            end else begin
              // latch match flags in every cell, then scan from cell 0
              ctrl.mode      = CM_MATCH;
              rsp_valid_next = 1'b0;
              scan_next      = '0;
              state_next     = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      // cell 0 now holds the flag of list index 'scan'
      if (hit_q[0]) begin
        rsp_valid_next       = 1'b1;
        rsp_next.status      = ST_OK;
        rsp_next.found_index = scan_x[7:0];
        state_next           = S_IDLE;
      end else if (scan_x + XW'(1) == cnt_x) begin
        rsp_valid_next       = 1'b1;
        rsp_next.status      = ST_NOTFOUND;
        rsp_next.found_index = IDX_NONE;
        state_next           = S_IDLE;
      end else begin
        ctrl.mode = CM_SHIFT;
        scan_next = scan + IW'(1);
      end
    end

    rsp_next.count    = cnt_next_x[7:0];
    rsp_next.is_empty = (count_next == '0);
    rsp_next.is_full  = (count_next == CW'(LIST_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    scan <= scan_next;
    rsp  <= rsp_next;
  end

  // --------------------------------------------------------------------------
  // Row of cells: each passes its word right on insert, left on delete,
  // and its match flag left during a scan. Cell 0 sees the insert value on its left;
  // the last cell sees its own word and a clear flag on its right.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [31:0] prev_entry;
    logic [31:0] next_entry;
    logic        next_hit;

    if (i == 0) begin : g_first
      assign prev_entry = ctrl.value;
    end else begin : g_mid_prev
      assign prev_entry = entry_q[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign next_entry = entry_q[i];
      assign next_hit   = 1'b0;
    end else begin : g_mid_next
      assign next_entry = entry_q[i+1];
      assign next_hit   = hit_q[i+1];
    end

    pal_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .next_hit   (next_hit),
      .entry      (entry_q[i]),
      .hit        (hit_q[i])
    );
  end

endmodule
